// ----- sv/bridge_control_register_file_defines.svh -----
// assertion macros used by the bridge register file rtl
`ifndef BRIDGE_CONTROL_REGISTER_FILE_DEFINES_SVH
`define BRIDGE_CONTROL_REGISTER_FILE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CRF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CRF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/crf_pkg.sv -----
// types and constants of the bridge control register file
`default_nettype none

package crf_pkg;

    localparam int PAGE_BYTES     = 4096;
    localparam int SLOT_COUNT_DEF = 14;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;

    localparam logic [7:0]  REG_RESET     = 8'h00;
    localparam logic [7:0]  REG_WAIT      = 8'h01;
    localparam logic [7:0]  REG_ID        = 8'h08;
    localparam logic [7:0]  REG_SLOT_E    = 8'h11;
    localparam logic [7:0]  REG_BURST_TOP = 8'h80;
    localparam logic [7:0]  REG_LIMIT     = 8'h88;
    localparam logic [31:0] ID_PROTO      = 32'h4318_4000;
    localparam logic [7:0]  FAULT_BYTE    = 8'hFF;

    typedef struct packed {
        logic        action;
        logic [1:0]  access_size;
        logic [11:0] offset;
        logic [31:0] write_data;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] read_data;
        logic        bus_error;
        logic        reset_pulse;
        logic [31:0] pulse_count;
    } t_out_beat;

endpackage

`default_nettype wire

// ----- sv/crf_regs.sv -----
// register storage and byte-lane decode of one bus access
`default_nettype none

module crf_regs #(
    parameter int SLOT_COUNT = crf_pkg::SLOT_COUNT_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_commit,
    input  wire logic              i_present,
    input  wire crf_pkg::t_in_beat i_access,
    output crf_pkg::t_out_beat     o_result
);

    localparam int SLOT_IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic [7:0]  r_burst [SLOT_COUNT];
    logic [7:0]  r_wait, n_wait;
    logic [7:0]  r_slot_e, n_slot_e;
    logic [31:0] r_pulse_total, n_pulse_total;

    logic [11:0]        w_base;
    logic [2:0]         w_nbytes;
    logic [2:0]         w_slot_lane;
    logic [12:0]        w_slot_addr;
    logic [7:0]         w_slot_dist;
    logic [4:0]         w_slot_pos;
    logic               w_slot_hit;
    logic [SLOT_IW-1:0] w_slot_idx;
    logic [7:0]         w_burst_rd;
    logic               w_burst_we;
    logic [7:0]         w_burst_wdata;
    logic               w_do_write;
    logic               w_pulse;
    logic               w_fault;
    logic [31:0]        w_lane_rdata;
    logic [31:0]        w_rdata;
    logic [31:0]        w_ones;

    always_comb begin
        w_base = 12'(32'(i_access.offset) % crf_pkg::PAGE_BYTES);
        case (i_access.access_size)
            crf_pkg::SIZE_BYTE: begin
                w_nbytes = 3'd1;
                w_ones   = 32'h0000_00FF;
            end
            crf_pkg::SIZE_HALF: begin
                w_nbytes = 3'd2;
                w_ones   = 32'h0000_FFFF;
            end
            default: begin
                w_nbytes = 3'd4;
                w_ones   = 32'hFFFF_FFFF;
            end
        endcase
        // slots sit 8 apart, so at most one lane of an access can hit one
        w_slot_lane = 3'(4'd8 - {1'b0, w_base[2:0]});
        w_slot_addr = {1'b0, w_base} + 13'(w_slot_lane);
        w_slot_dist = 8'(13'(crf_pkg::REG_BURST_TOP) - w_slot_addr);
        w_slot_pos  = w_slot_dist[7:3];
        w_slot_hit  = (w_slot_lane < w_nbytes)
                   && (w_slot_addr <= 13'(crf_pkg::REG_BURST_TOP))
                   && (32'(w_slot_pos) < SLOT_COUNT);
        w_slot_idx  = SLOT_IW'(w_slot_pos);
        w_burst_rd  = w_slot_hit ? r_burst[w_slot_idx] : 8'h00;
    end

    always_comb begin
        logic [12:0] lane_addr;
        logic [1:0]  sh;
        logic [7:0]  wr_byte;
        logic [7:0]  rd_byte;
        logic        lane_fault;
        lane_addr     = '0;
        sh            = '0;
        wr_byte       = '0;
        rd_byte       = '0;
        lane_fault    = 1'b0;
        w_do_write    = i_access.action && i_present;
        w_fault       = 1'b0;
        w_pulse       = 1'b0;
        w_lane_rdata  = '0;
        w_burst_we    = 1'b0;
        w_burst_wdata = '0;
        n_wait        = r_wait;
        n_slot_e      = r_slot_e;
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < w_nbytes) begin
                lane_addr  = {1'b0, w_base} + 13'(i);
                sh         = 2'(w_nbytes - 3'(i) - 3'd1);
                wr_byte    = 8'(i_access.write_data >> {sh, 3'b000});
                lane_fault = lane_addr >= 13'(crf_pkg::REG_LIMIT);
                w_fault    = w_fault | lane_fault;
                if (lane_fault) begin
                    rd_byte = crf_pkg::FAULT_BYTE;
                end else if (w_slot_hit && w_slot_lane == 3'(i)) begin
                    rd_byte = w_burst_rd;
                end else if (lane_addr == 13'(crf_pkg::REG_WAIT)) begin
                    rd_byte = r_wait;
                end else if (lane_addr == 13'(crf_pkg::REG_SLOT_E)) begin
                    rd_byte = r_slot_e;
                end else begin
                    rd_byte = 8'h00;
                end
                w_lane_rdata = w_lane_rdata | (32'(rd_byte) << {sh, 3'b000});
                if (w_do_write && !lane_fault) begin
                    if (w_slot_hit && w_slot_lane == 3'(i)) begin
                        w_burst_we    = 1'b1;
                        w_burst_wdata = wr_byte;
                    end else if (lane_addr == 13'(crf_pkg::REG_RESET)) begin
                        w_pulse = wr_byte[7];
                    end else if (lane_addr == 13'(crf_pkg::REG_WAIT)) begin
                        n_wait = wr_byte;
                    end else if (lane_addr == 13'(crf_pkg::REG_SLOT_E)) begin
                        n_slot_e = wr_byte;
                    end
                end
            end
        end
        n_pulse_total = r_pulse_total + 32'(w_pulse);
    end

    always_comb begin
        if (!i_present) begin
            w_rdata = i_access.action ? 32'h0 : w_ones;
        end else if (i_access.action) begin
            w_rdata = 32'h0;
        end else if (w_nbytes == 3'd4 && w_base == 12'(crf_pkg::REG_ID)) begin
            w_rdata = ~crf_pkg::ID_PROTO;
        end else begin
            w_rdata = w_lane_rdata;
        end
        o_result.read_data   = w_rdata;
        // the identity longword never reaches the fault limit, so lane faults stand
        o_result.bus_error   = !i_present || w_fault;
        o_result.reset_pulse = w_pulse;
        o_result.pulse_count = n_pulse_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOT_COUNT; s++) begin
                r_burst[s] <= 8'h00;
            end
            r_wait        <= 8'h00;
            r_slot_e      <= 8'h00;
            r_pulse_total <= 32'h0;
        end else if (i_commit) begin
            if (w_burst_we) begin
                r_burst[w_slot_idx] <= w_burst_wdata;
            end
            r_wait        <= n_wait;
            r_slot_e      <= n_slot_e;
            r_pulse_total <= n_pulse_total;
        end
    end

endmodule

`default_nettype wire

// ----- sv/bridge_control_register_file.sv -----
// Bridge control register file: one bus access in, one result out. An access is registered on
// entry, decoded byte by byte against the burst-enable, wait-state and slot-E registers, and its
// result is held in an output register, which offers it once the access has moved on from the
// input register. A new access is taken every cycle while the output side keeps up. With the
// input register full, input ready is high when the output register is empty or output ready
// is high. Bytes at 0x88 and above fault and read 0xFF; a longword read at 0x08 returns the
// inverted prototype ID; writing bit 7 of the byte at 0x00 raises reset_pulse and bumps
// pulse_count. Clearing bridge_present through the configuration port makes every access fault.
`default_nettype none

`include "bridge_control_register_file_defines.svh"

module bridge_control_register_file #(
    parameter int SLOT_COUNT = crf_pkg::SLOT_COUNT_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire crf_pkg::t_in_beat  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output crf_pkg::t_out_beat      o_out_data,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_data
);

    crf_pkg::t_in_beat  r_in;
    logic               r_in_valid;
    crf_pkg::t_out_beat r_out;
    logic               r_out_valid;
    logic               r_present;

    crf_pkg::t_out_beat w_result;
    logic               w_advance;

    // the registered beat moves on whenever the result slot is free or being emptied
    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    crf_regs #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_commit  (w_advance),
        .i_present (r_present),
        .i_access  (r_in),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_present   <= 1'b1;
        end else begin
            if (i_cfg_valid) begin
                r_present <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    `CRF_ASSERT_SAME(a_pulse_no_fault, r_out_valid && r_out.reset_pulse, !r_out.bus_error, "reset pulse on a faulting access")
    `CRF_ASSERT_NEXT(a_absent_faults, w_advance && !r_present, r_out_valid && r_out.bus_error, "access without bridge did not fault")
    `CRF_ASSERT_SAME(a_held_beat_blocks, r_in_valid && !w_advance, !o_in_ready, "held beat open to overwrite")

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// self-checking testbench for the bridge control register file
module tb;

    localparam logic       ACT_READ      = 1'b0;
    localparam logic       ACT_WRITE     = 1'b1;
    localparam logic [1:0] SIZE_LONG     = 2'd2;
    localparam logic [1:0] SIZE_RESERVED = 2'd3;
    localparam int         IDLE_LIMIT    = 2000;
    localparam int         LONG_HOLD     = 80;

    typedef enum {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_ALTERNATE} t_rx_mode;

    typedef struct {
        bit                 reconf;
        bit                 present_val;
        crf_pkg::t_in_beat  beat;
        bit                 known;
        crf_pkg::t_out_beat want;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    crf_pkg::t_in_beat  i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    crf_pkg::t_out_beat o_out_data;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic               i_cfg_data;

    bridge_control_register_file u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // register file as the bench sees it
    logic [7:0]  burst_bytes [crf_pkg::SLOT_COUNT_DEF] = '{default: 8'h00};
    logic [7:0]  wait_byte = 8'h00;
    logic [7:0]  slot_e_byte = 8'h00;
    logic [31:0] pulse_total = 32'd0;
    bit          present = 1'b1;

    crf_pkg::t_out_beat pending_results [$];

    int fail_count;
    int accesses_sent;
    int results_checked;
    int faults_seen;
    int pulses_seen;
    int cfg_writes;
    int burst_left;
    int idle_cycles;

    t_rx_mode rx_mode;
    int       rx_stretch;
    int       hold_left;
    bit       long_hold_done;
    bit       ready_next;

    // directed accesses; known rows carry the result straight off the register map
    t_row directed_rows [0:25] = '{
        '{1'b0, 1'b1, '{ACT_READ,  crf_pkg::SIZE_BYTE, 12'h001, 32'h0000_0000}, 1'b1,
          '{32'h0000_0000, 1'b0, 1'b0, 32'd0}},
        '{1'b0, 1'b1, '{ACT_READ,  SIZE_LONG,          12'h008, 32'h0000_0000}, 1'b1,
          '{32'hBCE7_BFFF, 1'b0, 1'b0, 32'd0}},
        '{1'b0, 1'b1, '{ACT_READ,  SIZE_RESERVED,      12'h008, 32'hFFFF_FFFF}, 1'b1,
          '{32'hBCE7_BFFF, 1'b0, 1'b0, 32'd0}},
        '{1'b0, 1'b1, '{ACT_READ,  SIZE_LONG,          12'h084, 32'h0000_0000}, 1'b1,
          '{32'h0000_0000, 1'b0, 1'b0, 32'd0}},
        '{1'b0, 1'b1, '{ACT_READ,  SIZE_LONG,          12'h086, 32'h0000_0000}, 1'b1,
          '{32'h0000_FFFF, 1'b1, 1'b0, 32'd0}},
        '{1'b0, 1'b1, '{ACT_READ,  crf_pkg::SIZE_BYTE, 12'hFFF, 32'h0000_0000}, 1'b1,
          '{32'h0000_00FF, 1'b1, 1'b0, 32'd0}},
        '{1'b0, 1'b1, '{ACT_WRITE, crf_pkg::SIZE_BYTE, 12'h000, 32'h0000_0080}, 1'b1,
          '{32'h0000_0000, 1'b0, 1'b1, 32'd1}},
        '{1'b0, 1'b1, '{ACT_WRITE, crf_pkg::SIZE_BYTE, 12'h000, 32'hFFFF_FF7F}, 1'b1,
          '{32'h0000_0000, 1'b0, 1'b0, 32'd1}},
        '{1'b0, 1'b1, '{ACT_WRITE, crf_pkg::SIZE_HALF, 12'h000, 32'h0000_FFFF}, 1'b0, '0},
        '{1'b0, 1'b1, '{ACT_READ,  crf_pkg::SIZE_HALF, 12'h000, 32'h0000_0000}, 1'b0, '0},
        '{1'b0, 1'b1, '{ACT_WRITE, SIZE_LONG,          12'h080, 32'hA511_2233}, 1'b0, '0},
        '{1'b0, 1'b1, '{ACT_WRITE, SIZE_LONG,          12'h018, 32'hFFFF_FFFF}, 1'b0, '0},
        '{1'b0, 1'b1, '{ACT_WRITE, crf_pkg::SIZE_BYTE, 12'h011, 32'h0000_005A}, 1'b0, '0},
        '{1'b0, 1'b1, '{ACT_READ,  SIZE_LONG,          12'h010, 32'h0000_0000}, 1'b0, '0},
        '{1'b0, 1'b1, '{ACT_READ,  SIZE_LONG,          12'h07E, 32'h0000_0000}, 1'b0, '0},
        '{1'b0, 1'b1, '{ACT_WRITE, SIZE_LONG,          12'h086, 32'h1234_5678}, 1'b0, '0},
        '{1'b0, 1'b1, '{ACT_READ,  SIZE_LONG,          12'h009, 32'h0000_0000}, 1'b0, '0},
        '{1'b0, 1'b1, '{ACT_WRITE, SIZE_LONG,          12'hFFC, 32'hFFFF_FFFF}, 1'b0, '0},
        '{1'b0, 1'b1, '{ACT_READ,  crf_pkg::SIZE_BYTE, 12'h008, 32'h0000_0000}, 1'b0, '0},
        '{1'b0, 1'b1, '{ACT_READ,  SIZE_LONG,          12'h018, 32'h0000_0000}, 1'b0, '0},
        '{1'b1, 1'b0, '{ACT_READ,  SIZE_LONG,          12'h080, 32'h0000_0000}, 1'b0, '0},
        '{1'b0, 1'b0, '{ACT_WRITE, crf_pkg::SIZE_BYTE, 12'h000, 32'h0000_0080}, 1'b0, '0},
        '{1'b0, 1'b0, '{ACT_READ,  crf_pkg::SIZE_BYTE, 12'h001, 32'h0000_0000}, 1'b0, '0},
        '{1'b0, 1'b0, '{ACT_READ,  crf_pkg::SIZE_HALF, 12'h020, 32'h0000_0000}, 1'b0, '0},
        '{1'b1, 1'b1, '{ACT_READ,  crf_pkg::SIZE_BYTE, 12'h080, 32'h0000_0000}, 1'b0, '0},
        '{1'b0, 1'b1, '{ACT_WRITE, crf_pkg::SIZE_HALF, 12'h07F, 32'hFFFF_FFFF}, 1'b0, '0}
    };

    // burst slot behind a byte address, -1 when there is none
    function automatic int burst_slot(int unsigned addr);
        int unsigned span;
        if (addr > crf_pkg::REG_BURST_TOP)
            return -1;
        span = crf_pkg::REG_BURST_TOP - addr;
        if (span % 8 != 0 || span / 8 >= crf_pkg::SLOT_COUNT_DEF)
            return -1;
        return int'(span / 8);
    endfunction

    // works out the result of one access and updates the register image
    function automatic crf_pkg::t_out_beat decode_access(crf_pkg::t_in_beat beat);
        crf_pkg::t_out_beat res;
        int unsigned        nbytes;
        int unsigned        addr;
        int                 slot;
        logic [7:0]         val;
        res = '0;
        nbytes = (beat.access_size == crf_pkg::SIZE_BYTE) ? 1 :
                 (beat.access_size == crf_pkg::SIZE_HALF) ? 2 : 4;
        if (!present) begin
            res.bus_error = 1'b1;
            if (beat.action == ACT_READ)
                res.read_data = (nbytes == 4) ? 32'hFFFF_FFFF : (32'd1 << (8 * nbytes)) - 1;
        end else if (beat.action == ACT_WRITE) begin
            for (int i = 0; i < nbytes; i++) begin
                addr = beat.offset + i;
                val = 8'(beat.write_data >> (8 * (nbytes - 1 - i)));
                slot = burst_slot(addr);
                if (addr >= crf_pkg::REG_LIMIT) begin
                    res.bus_error = 1'b1;
                end else if (slot >= 0) begin
                    burst_bytes[slot] = val;
                end else if (addr == crf_pkg::REG_RESET) begin
                    if (val[7]) begin
                        pulse_total = pulse_total + 1;
                        res.reset_pulse = 1'b1;
                    end
                end else if (addr == crf_pkg::REG_WAIT) begin
                    wait_byte = val;
                end else if (addr == crf_pkg::REG_SLOT_E) begin
                    slot_e_byte = val;
                end
            end
        end else if (nbytes == 4 && beat.offset == crf_pkg::REG_ID) begin
            res.read_data = ~crf_pkg::ID_PROTO;
        end else begin
            for (int i = 0; i < nbytes; i++) begin
                addr = beat.offset + i;
                slot = burst_slot(addr);
                if (addr >= crf_pkg::REG_LIMIT) begin
                    res.bus_error = 1'b1;
                    val = crf_pkg::FAULT_BYTE;
                end else if (slot >= 0) begin
                    val = burst_bytes[slot];
                end else if (addr == crf_pkg::REG_WAIT) begin
                    val = wait_byte;
                end else if (addr == crf_pkg::REG_SLOT_E) begin
                    val = slot_e_byte;
                end else begin
                    val = 8'h00;
                end
                res.read_data = {res.read_data[23:0], val};
            end
        end
        res.pulse_count = pulse_total;
        return res;
    endfunction

    // offsets lean towards the mapped registers and the fault boundary
    function automatic crf_pkg::t_in_beat random_access();
        crf_pkg::t_in_beat beat;
        int unsigned       pick;
        beat.action = $urandom_range(0, 1) ? ACT_WRITE : ACT_READ;
        pick = $urandom_range(0, 9);
        beat.access_size = (pick < 3) ? crf_pkg::SIZE_BYTE : (pick < 6) ? crf_pkg::SIZE_HALF :
                           (pick < 9) ? SIZE_LONG : SIZE_RESERVED;
        beat.write_data = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            beat.offset = $urandom_range(0, 12'h08F);
        end else if (pick < 80) begin
            case ($urandom_range(0, 5))
                0: beat.offset = crf_pkg::REG_RESET;
                1: beat.offset = crf_pkg::REG_WAIT;
                2: beat.offset = crf_pkg::REG_ID;
                3: beat.offset = crf_pkg::REG_SLOT_E;
                4: beat.offset = crf_pkg::REG_BURST_TOP
                                 - 8 * $urandom_range(0, crf_pkg::SLOT_COUNT_DEF - 1);
                default: beat.offset = crf_pkg::REG_LIMIT - $urandom_range(1, 3);
            endcase
        end else begin
            beat.offset = $urandom_range(0, 4095);
        end
        return beat;
    endfunction

    // offers one access, in bursts with random gaps in between
    task automatic send_access(crf_pkg::t_in_beat beat, bit known, crf_pkg::t_out_beat fixed);
        crf_pkg::t_out_beat res;
        int                 gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 30);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data <= beat;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
        accesses_sent++;
        res = decode_access(beat);
        if (res.bus_error)
            faults_seen++;
        if (res.reset_pulse)
            pulses_seen++;
        pending_results.push_back(known ? fixed : res);
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_bridge_present(bit val);
        wait_for_drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        present = val;
        cfg_writes++;
    endtask

    task automatic check_result(crf_pkg::t_out_beat got);
        crf_pkg::t_out_beat want;
        if (pending_results.size() == 0) begin
            $error("result beat with nothing pending: %h", got);
            fail_count++;
        end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (got.read_data !== want.read_data) begin
                $error("read_data: expected %h, got %h", want.read_data, got.read_data);
                fail_count++;
            end
            if (got.bus_error !== want.bus_error) begin
                $error("bus_error: expected %b, got %b", want.bus_error, got.bus_error);
                fail_count++;
            end
            if (got.reset_pulse !== want.reset_pulse) begin
                $error("reset_pulse: expected %b, got %b", want.reset_pulse, got.reset_pulse);
                fail_count++;
            end
            if (got.pulse_count !== want.pulse_count) begin
                $error("pulse_count: expected %0d, got %0d", want.pulse_count, got.pulse_count);
                fail_count++;
            end
        end
    endtask

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // result side: check the beat, then pick the next ready value
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready)
                check_result(o_out_data);
            if (!long_hold_done && results_checked >= 400) begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else begin
                if (rx_stretch == 0) begin
                    case ($urandom_range(0, 3))
                        0: rx_mode = RX_OPEN;
                        1: rx_mode = RX_RANDOM;
                        2: rx_mode = RX_SPARSE;
                        default: rx_mode = RX_ALTERNATE;
                    endcase
                    rx_stretch = $urandom_range(1, 40);
                end
                rx_stretch--;
                case (rx_mode)
                    RX_OPEN:   ready_next = 1'b1;
                    RX_RANDOM: ready_next = $urandom_range(0, 1);
                    RX_SPARSE: ready_next = ($urandom_range(0, 3) == 0);
                    default:   ready_next = ~i_out_ready;
                endcase
            end
            i_out_ready <= ready_next;
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results pending",
                     idle_cycles, pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].reconf)
                write_bridge_present(directed_rows[r].present_val);
            send_access(directed_rows[r].beat, directed_rows[r].known, directed_rows[r].want);
        end

        // the bridge is absent in one short phase only
        for (int phase = 0; phase < 6; phase++) begin
            write_bridge_present(phase != 1);
            repeat ((phase == 1) ? 100 : 250)
                send_access(random_access(), 1'b0, '0);
        end

        wait_for_drain();
        repeat (10) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d result beats never arrived", pending_results.size());
            fail_count++;
        end
        $display("covered %0d accesses and %0d result beats over %0d bridge_present writes",
                 accesses_sent, results_checked, cfg_writes);
        $display("of which %0d faulted and %0d raised a bus reset pulse; %0d mismatches",
                 faults_seen, pulses_seen, fail_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/crf_pkg.sv
sv/crf_regs.sv
sv/bridge_control_register_file.sv
bench/tb.sv
